>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain invariant checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

>>> hdl/mpd_pkg.sv
package mpd_pkg;

  // Position of the line-feed byte that completes a packet.
  localparam logic [3:0] LAST_POS = 4'd13;

  localparam logic [7:0] CR_BYTE = 8'h0d;
  localparam logic [7:0] LF_BYTE = 8'h0a;

  // Function byte codes.
  localparam logic [7:0] FN_VOLT    = 8'h3b;
  localparam logic [7:0] FN_UA      = 8'h3d;
  localparam logic [7:0] FN_MA      = 8'h3f;
  localparam logic [7:0] FN_A_AUTO  = 8'h30;
  localparam logic [7:0] FN_A_MAN   = 8'h39;
  localparam logic [7:0] FN_OHM     = 8'h33;
  localparam logic [7:0] FN_CONT    = 8'h35;
  localparam logic [7:0] FN_DIODE   = 8'h31;
  localparam logic [7:0] FN_FREQ    = 8'h32;
  localparam logic [7:0] FN_CAP     = 8'h36;
  localparam logic [7:0] FN_TEMP    = 8'h34;
  localparam logic [7:0] FN_ADP0    = 8'h3e;
  localparam logic [7:0] FN_ADP1    = 8'h3c;
  localparam logic [7:0] FN_ADP2    = 8'h38;
  localparam logic [7:0] FN_ADP3    = 8'h3a;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TERM = 3'd1,
    ST_BAD_FUNC = 3'd2,
    ST_ACDC     = 3'd3,
    ST_BAD_DIG  = 3'd4,
    ST_BAD_RNG  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    KD_VOLT  = 3'd0,
    KD_CUR   = 3'd1,
    KD_OHM   = 3'd2,
    KD_CONT  = 3'd3,
    KD_DIODE = 3'd4,
    KD_FREQ  = 3'd5,
    KD_DUTY  = 3'd6,
    KD_CAP   = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    RW_V      = 4'd0,
    RW_UA     = 4'd1,
    RW_MA     = 4'd2,
    RW_A_AUTO = 4'd3,
    RW_A_MAN  = 4'd4,
    RW_OHM    = 4'd5,
    RW_HZ     = 4'd6,
    RW_F      = 4'd7,
    RW_DIODE  = 4'd8
  } row_t;

  // One decoded packet, status in the lowest bits.
  typedef struct packed {
    logic [13:0]        flags;
    logic [2:0]         range_index;
    logic [3:0]         mode_row;
    logic [2:0]         kind;
    logic signed [17:0] value;
    logic [2:0]         status;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> hdl/multimeter_packet_decoder.sv
// Decodes the 14-byte serial multimeter packet. One byte is taken per cycle;
// a high s_tuser marks byte 0 and restarts the packet. The five digit bytes
// are folded into a running magnitude as they arrive (one multiply-by-ten and
// add per byte), and the other bytes that matter are kept in registers. The
// line-feed byte is decoded in the cycle it is taken and the result appears on
// the m_ side in the next cycle, and no gap is needed between packets. Bytes
// that complete no packet are taken even while a result waits; only the final
// byte waits for the result register to free up.
`include "assert_macros.svh"

module multimeter_packet_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,  // rx_byte
  input  logic                        s_tuser,  // first
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status, value, kind, mode_row, range_index, flags, zero fill
  output logic [mpd_pkg::TDATA_W-1:0] m_tdata
);
  import mpd_pkg::*;

  logic [3:0]  pos;
  logic [3:0]  pos_eff;
  logic [7:0]  range_byte;
  logic [7:0]  func_byte;
  logic [3:0]  stat_bits;
  logic [3:0]  opt_a;
  logic [3:0]  opt_b;
  logic [3:0]  opt_c;
  logic [7:0]  cr_byte;
  logic [16:0] mag;
  logic [16:0] mag_next;
  logic        digits_ok;
  logic        digit_valid;
  logic        completes;
  logic        accept;
  result_t     res;
  result_t     res_next;

  assign pos_eff     = s_tuser ? 4'd0 : pos;
  assign completes   = pos_eff == LAST_POS;
  assign s_tready    = !m_tvalid || m_tready || !completes;
  assign accept      = s_tvalid && s_tready;
  assign digit_valid = (s_tdata[7:4] == 4'h3) && (s_tdata[3:0] <= 4'd9);
  assign mag_next    = (pos_eff == 4'd1) ? {13'd0, s_tdata[3:0]}
                     : (mag << 3) + (mag << 1) + {13'd0, s_tdata[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
    end else if (accept) begin
      pos <= completes ? 4'd0 : pos_eff + 4'd1;
    end
  end

  // Packet byte capture; digits accumulate into the magnitude as they arrive.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos_eff)
        4'd0: begin
          range_byte <= s_tdata;
        end
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
          mag       <= mag_next;
          digits_ok <= digit_valid && ((pos_eff == 4'd1) || digits_ok);
        end
        4'd6:  func_byte <= s_tdata;
        4'd7:  stat_bits <= s_tdata[3:0];
        4'd8:  opt_a     <= s_tdata[3:0];
        4'd9:  opt_b     <= s_tdata[3:0];
        4'd10: opt_c     <= s_tdata[3:0];
        4'd12: cr_byte   <= s_tdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic judge, sign, batt, ol, ul, dc, ac, autom, vahz;
    logic volt, cur, micro, milli, ohm, cont, diode, freq, duty, cap, unsup, func_ok;
    kind_t kd;
    row_t  rw;

    judge = stat_bits[3];
    sign  = stat_bits[2];
    batt  = stat_bits[1];
    ol    = stat_bits[0];
    ul    = opt_b[3];
    dc    = opt_c[3];
    ac    = opt_c[2];
    autom = opt_c[1];
    vahz  = opt_c[0];
    volt  = 1'b0;
    cur   = 1'b0;
    micro = 1'b0;
    milli = 1'b0;
    ohm   = 1'b0;
    cont  = 1'b0;
    diode = 1'b0;
    freq  = 1'b0;
    duty  = 1'b0;
    cap   = 1'b0;
    unsup = 1'b0;
    func_ok = 1'b1;

    case (func_byte)
      FN_VOLT:   volt = 1'b1;
      FN_UA: begin
        cur = 1'b1; micro = 1'b1; autom = 1'b1;
      end
      FN_MA: begin
        cur = 1'b1; milli = 1'b1; autom = 1'b1;
      end
      FN_A_AUTO: begin
        cur = 1'b1; autom = 1'b1;
      end
      FN_A_MAN: begin
        cur = 1'b1; autom = 1'b0;
      end
      FN_OHM:    ohm = 1'b1;
      FN_CONT:   cont = 1'b1;
      FN_DIODE:  diode = 1'b1;
      FN_FREQ: begin
        duty = judge; freq = !judge;
      end
      FN_CAP:    cap = 1'b1;
      FN_TEMP, FN_ADP0, FN_ADP1, FN_ADP2, FN_ADP3: unsup = 1'b1;
      default:   func_ok = 1'b0;
    endcase

    // The frequency key on a voltage or current range turns it into a Hz reading, or a duty reading when judge is set.
    if (vahz && (volt || cur)) begin
      volt  = 1'b0;
      cur   = 1'b0;
      micro = 1'b0;
      milli = 1'b0;
      duty  = duty || judge;
      freq  = freq || !judge;
    end

    if (volt) begin
      kd = KD_VOLT;  rw = RW_V;
    end else if (cur) begin
      kd = KD_CUR;
      rw = micro ? RW_UA : milli ? RW_MA : autom ? RW_A_AUTO : RW_A_MAN;
    end else if (ohm) begin
      kd = KD_OHM;   rw = RW_OHM;
    end else if (cont) begin
      kd = KD_CONT;  rw = RW_OHM;
    end else if (freq) begin
      kd = KD_FREQ;  rw = RW_HZ;
    end else if (cap) begin
      kd = KD_CAP;   rw = RW_F;
    end else if (diode) begin
      kd = KD_DIODE; rw = RW_DIODE;
    end else begin
      kd = KD_DUTY;  rw = RW_V;
    end

    res_next             = '0;
    res_next.kind        = kd;
    res_next.mode_row    = rw;
    res_next.range_index = range_byte[2:0];
    res_next.flags       = {ol, batt, judge, vahz, autom, ac, dc, opt_b[1], opt_b[2], ul,
                            opt_a[0], opt_a[1], opt_a[2], opt_a[3]};
    if (!(ol || ul)) begin
      res_next.value = sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    if (cr_byte != CR_BYTE || s_tdata != LF_BYTE) begin
      res_next = '0;
      res_next.status = ST_BAD_TERM;
    end else if (!func_ok) begin
      res_next = '0;
      res_next.status = ST_BAD_FUNC;
    end else if (ac && dc) begin
      res_next = '0;
      res_next.status = ST_ACDC;
    end else if (!(ol || ul) && !digits_ok) begin
      res_next = '0;
      res_next.status = ST_BAD_DIG;
    end else if (range_byte[7:3] != 5'b00110 || unsup) begin
      res_next = '0;
      res_next.status = ST_BAD_RNG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && completes) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && completes) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(TDATA_W - RESULT_W){1'b0}}, res};

  `ASSERT_ALWAYS(a_pos_range, pos <= LAST_POS, "byte position beyond packet end")
  `ASSERT_CLK(a_done_gives_result, (accept && completes) |=> m_tvalid,
              "completed packet produced no result")
  `ASSERT_CLK(a_error_clears,
              (m_tvalid && res.status != ST_OK) |-> (res.value == '0 && res.flags == '0),
              "error result carries nonzero fields")
  `ASSERT_CLK(a_ol_zero_value,
              (m_tvalid && (res.flags[13] || res.flags[4])) |-> (res.value == '0),
              "overrange result carries a value")
endmodule
